@@ sv/local_mds_pair_gradient_accumulator_macros.svh @@
// assertion helpers for the pair gradient accumulator
`ifndef LOCAL_MDS_PAIR_GRADIENT_ACCUMULATOR_MACROS_SVH
`define LOCAL_MDS_PAIR_GRADIENT_ACCUMULATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LMGA_ASSERT_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("lmga assertion failed");

// antecedent implies consequent in the next cycle
`define LMGA_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("lmga assertion failed");

`endif

@@ sv/lmga_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lmga_pkg;

  localparam int unsigned IterW = 96;
  localparam int unsigned CntW = 7;

  localparam logic [62:0] SumMax = {63{1'b1}};
  localparam logic [16:0] WeightOne = 17'd65536;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } iter_op_e;

  // launch request for the shared iterative unit
  typedef struct packed {
    logic            start;
    iter_op_e        op;
    logic [CntW-1:0] nbits;
  } iter_req_t;

endpackage
`default_nettype wire

@@ sv/lmga_iter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lmga_iter_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire lmga_pkg::iter_req_t        req_i,
  input  wire logic [lmga_pkg::IterW-1:0] a_i,
  input  wire logic [lmga_pkg::IterW-1:0] b_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [lmga_pkg::IterW-1:0]      res_o
);
  import lmga_pkg::*;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  iter_op_e        op_q, op_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IterW-1:0] src_q, src_d;
  logic [IterW-1:0] opd_q, opd_d;
  logic [IterW-1:0] res_q, res_d;
  logic [IterW-1:0] rem_q, rem_d;

  logic [CntW-1:0]  k;
  logic [CntW-1:0]  idx_hi;
  logic [CntW-1:0]  idx_lo;
  logic [IterW-1:0] trial;
  logic [IterW-1:0] sub;
  logic [IterW:0]   diff;
  logic             ge;
  logic [IterW-1:0] mul_sum;

  // one step: shift-add, restoring divide or digit-by-digit root
  always_comb begin
    k       = cnt_q - CntW'(1);
    idx_hi  = {k[CntW-2:0], 1'b1};
    idx_lo  = {k[CntW-2:0], 1'b0};
    mul_sum = {res_q[IterW-2:0], 1'b0} + (src_q[k] ? opd_q : '0);
    if (op_q == OP_SQRT) begin
      trial = {rem_q[IterW-3:0], src_q[idx_hi], src_q[idx_lo]};
      sub   = {res_q[IterW-3:0], 2'b01};
    end else begin
      trial = {rem_q[IterW-2:0], src_q[k]};
      sub   = opd_q;
    end
    diff = {1'b0, trial} - {1'b0, sub};
    ge   = ~diff[IterW];
  end

  // sequencing of the iterations
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    src_d  = src_q;
    opd_d  = opd_q;
    res_d  = res_q;
    rem_d  = rem_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = req_i.nbits;
      src_d  = a_i;
      opd_d  = b_i;
      res_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          res_d = mul_sum;
        end
        OP_DIV, OP_SQRT: begin
          rem_d = ge ? diff[IterW-1:0] : trial;
          res_d = {res_q[IterW-2:0], ge};
        end
        default: begin
          res_d = res_q;
        end
      endcase
      cnt_d = k;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    opd_q <= opd_d;
    res_q <= res_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

@@ sv/local_mds_pair_gradient_accumulator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Local MDS pair gradient accumulator. Each pair transfer (point i, point j)
// computes the output distance by an exact integer square root, a lambda
// weight, the stress gradient term per axis and the weighted squared stress,
// and adds them into saturating accumulators. The pair marked last_pair_i
// produces one result transfer (gradient, its squared norm, cost sum) and
// clears the accumulators. All multiplies, divides and the root run on one
// shared bit-serial unit (shift-add multiply, restoring divide, root) under a
// small sequencer, so in_stall_o stays high while a pair is in work. The two
// divides are skipped when the output distance is zero, and a last pair also
// squares the gradient for its norm.
// A finished result waits in the output register while the next pair runs.
// Registers: lambda_weight at 0x0, neighborhood_radius at 0x4.
module local_mds_pair_gradient_accumulator (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] self_x_i,
  input  wire logic signed [31:0] self_y_i,
  input  wire logic signed [31:0] other_x_i,
  input  wire logic signed [31:0] other_y_i,
  input  wire logic [31:0]        orig_distance_i,
  input  wire logic [31:0]        final_threshold_i,
  input  wire logic               last_pair_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [47:0]      grad_x_o,
  output logic signed [47:0]      grad_y_o,
  output logic [62:0]             grad_sq_norm_o,
  output logic [62:0]             cost_sum_o
);
  import lmga_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_SQX   = 15'b000000000000010,
    S_SQY   = 15'b000000000000100,
    S_ROOT  = 15'b000000000001000,
    S_ERRW  = 15'b000000000010000,
    S_NUMX  = 15'b000000000100000,
    S_DIVX  = 15'b000000001000000,
    S_NUMY  = 15'b000000010000000,
    S_DIVY  = 15'b000000100000000,
    S_ERR2  = 15'b000001000000000,
    S_COST  = 15'b000010000000000,
    S_ACC   = 15'b000100000000000,
    S_NORMX = 15'b001000000000000,
    S_NORMY = 15'b010000000000000,
    S_EMIT  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic   launched_q, launched_d;

  // configuration registers
  logic [16:0] lambda_q;
  logic [31:0] radius_q;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? radius_q : {15'd0, lambda_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q <= 17'd32768;
      radius_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        radius_q <= pwdata;
      end else begin
        lambda_q <= pwdata[16:0];
      end
    end
  end

  // pair registers
  logic        in_xfer;
  logic [32:0] ax_q, ay_q;
  logic        xneg_q, yneg_q;
  logic [31:0] big_d_q, thr_q;
  logic        last_q;
  logic signed [32:0] dx, dy;

  assign in_xfer    = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign dx = $signed({other_x_i[31], other_x_i}) - $signed({self_x_i[31], self_x_i});
  assign dy = $signed({other_y_i[31], other_y_i}) - $signed({self_y_i[31], self_y_i});

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ax_q    <= dx[32] ? 33'(-dx) : 33'(dx);
      ay_q    <= dy[32] ? 33'(-dy) : 33'(dy);
      xneg_q  <= dx[32];
      yneg_q  <= dy[32];
      big_d_q <= orig_distance_i;
      thr_q   <= final_threshold_i;
      last_q  <= last_pair_i;
    end
  end

  // shared iterative unit
  iter_req_t        req;
  logic [IterW-1:0] opa, opb;
  logic             unit_busy, unit_done;
  logic [IterW-1:0] unit_res;

  lmga_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (opa),
    .b_i    (opb),
    .busy_o (unit_busy),
    .done_o (unit_done),
    .res_o  (unit_res)
  );

  // working registers
  logic [65:0] sq_q;
  logic [32:0] d_q;
  logic [32:0] err_q;
  logic        err_neg_q;
  logic [16:0] w_q;
  logic [49:0] ew_q;
  logic [82:0] num_q;
  logic [33:0] qx_q, qy_q;
  logic [62:0] cost_q;
  logic [62:0] nx_q, ny_q;

  // accumulators
  logic signed [47:0] gx_acc_q, gy_acc_q;
  logic [62:0]        cost_acc_q;

  // output register
  logic               out_valid_q;
  logic signed [47:0] out_gx_q, out_gy_q;
  logic [62:0]        out_norm_q, out_cost_q;
  logic               out_free;
  logic               emit;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (state_q == S_EMIT) && out_free;

  // weight and stress error from a fresh root
  logic [32:0] d_new;
  logic [16:0] lam;
  logic        err_neg_new;
  logic [32:0] err_new;
  logic [16:0] w_new;

  always_comb begin
    d_new       = unit_res[32:0];
    lam         = (lambda_q > WeightOne) ? WeightOne : lambda_q;
    err_neg_new = d_new > {1'b0, big_d_q};
    err_new     = err_neg_new ? d_new - {1'b0, big_d_q} : {1'b0, big_d_q} - d_new;
    w_new       = '0;
    if ((big_d_q < radius_q) || (big_d_q < thr_q)) begin
      w_new = lam;
    end
    if ((d_new < {1'b0, radius_q}) || (d_new < {1'b0, thr_q})) begin
      w_new = w_new + (WeightOne - lam);
    end
  end

  // cost term from the weighted squared error
  logic [62:0] cost_new;
  assign cost_new = (unit_res[95:79] != '0) ? SumMax : unit_res[78:16];

  // gradient terms and saturating updates
  logic signed [34:0] term_x, term_y;
  logic signed [49:0] sum_x, sum_y;
  logic signed [47:0] gx_next, gy_next;
  logic [63:0]        cost_sum;
  logic [62:0]        cost_next;
  logic [47:0]        gx_mag, gy_mag;
  logic [63:0]        norm_sum;
  logic [62:0]        norm_next;
  logic [62:0]        nsq_new;

  localparam logic signed [49:0] GradMax = 50'sh7FFF_FFFF_FFFF;
  localparam logic signed [49:0] GradMin = -50'sh8000_0000_0000;

  always_comb begin
    term_x = (err_neg_q ^ xneg_q) ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
    term_y = (err_neg_q ^ yneg_q) ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});
    sum_x  = 50'(gx_acc_q) + 50'(term_x);
    sum_y  = 50'(gy_acc_q) + 50'(term_y);
    if (sum_x > GradMax) begin
      gx_next = 48'(GradMax);
    end else if (sum_x < GradMin) begin
      gx_next = 48'(GradMin);
    end else begin
      gx_next = sum_x[47:0];
    end
    if (sum_y > GradMax) begin
      gy_next = 48'(GradMax);
    end else if (sum_y < GradMin) begin
      gy_next = 48'(GradMin);
    end else begin
      gy_next = sum_y[47:0];
    end
    cost_sum  = {1'b0, cost_acc_q} + {1'b0, cost_q};
    cost_next = (cost_sum >= {1'b0, SumMax}) ? SumMax : cost_sum[62:0];
    gx_mag    = gx_acc_q[47] ? 48'(-gx_acc_q) : 48'(gx_acc_q);
    gy_mag    = gy_acc_q[47] ? 48'(-gy_acc_q) : 48'(gy_acc_q);
    nsq_new   = (unit_res[95:63] != '0) ? SumMax : unit_res[62:0];
    norm_sum  = {1'b0, nx_q} + {1'b0, ny_q};
    norm_next = (norm_sum >= {1'b0, SumMax}) ? SumMax : norm_sum[62:0];
  end

  // operands for each step of the sequence
  always_comb begin
    req.start = 1'b0;
    req.op    = OP_MUL;
    req.nbits = CntW'(33);
    opa       = '0;
    opb       = '0;
    case (state_q)
      S_SQX: begin
        opa = IterW'(ax_q);
        opb = IterW'(ax_q);
      end
      S_SQY: begin
        opa = IterW'(ay_q);
        opb = IterW'(ay_q);
      end
      S_ROOT: begin
        req.op = OP_SQRT;
        opa    = IterW'(sq_q);
      end
      S_ERRW: begin
        req.nbits = CntW'(17);
        opa       = IterW'(w_q);
        opb       = IterW'(err_q);
      end
      S_NUMX: begin
        opa = IterW'(ax_q);
        opb = IterW'(ew_q);
      end
      S_NUMY: begin
        opa = IterW'(ay_q);
        opb = IterW'(ew_q);
      end
      S_DIVX, S_DIVY: begin
        req.op    = OP_DIV;
        req.nbits = CntW'(83);
        opa       = IterW'(num_q);
        opb       = IterW'({d_q, 16'd0});
      end
      S_ERR2: begin
        opa = IterW'(err_q);
        opb = IterW'(err_q);
      end
      S_COST: begin
        req.nbits = CntW'(17);
        opa       = IterW'(w_q);
        opb       = IterW'(sq_q);
      end
      S_NORMX: begin
        req.nbits = CntW'(48);
        opa       = IterW'(gx_mag);
        opb       = IterW'(gx_mag);
      end
      S_NORMY: begin
        req.nbits = CntW'(48);
        opa       = IterW'(gy_mag);
        opb       = IterW'(gy_mag);
      end
      default: begin
        opa = '0;
      end
    endcase
    req.start = !launched_q && (state_q != S_IDLE) && (state_q != S_ACC)
                && (state_q != S_EMIT);
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    launched_d = launched_q;
    if (req.start) begin
      launched_d = 1'b1;
    end
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_SQX;
        end
      end
      S_SQX: if (unit_done) state_d = S_SQY;
      S_SQY: if (unit_done) state_d = S_ROOT;
      S_ROOT: if (unit_done) state_d = S_ERRW;
      S_ERRW: begin
        if (unit_done) begin
          state_d = (d_q == '0) ? S_ERR2 : S_NUMX;
        end
      end
      S_NUMX: if (unit_done) state_d = S_DIVX;
      S_DIVX: if (unit_done) state_d = S_NUMY;
      S_NUMY: if (unit_done) state_d = S_DIVY;
      S_DIVY: if (unit_done) state_d = S_ERR2;
      S_ERR2: if (unit_done) state_d = S_COST;
      S_COST: if (unit_done) state_d = S_ACC;
      S_ACC: begin
        state_d = last_q ? S_NORMX : S_IDLE;
      end
      S_NORMX: if (unit_done) state_d = S_NORMY;
      S_NORMY: if (unit_done) state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (unit_done) begin
      launched_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      launched_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
    end
  end

  // capture of unit results
  always_ff @(posedge clk_i) begin
    if (unit_done) begin
      case (state_q)
        S_SQX: sq_q <= unit_res[65:0];
        S_SQY: sq_q <= sq_q + unit_res[65:0];
        S_ROOT: begin
          d_q       <= d_new;
          err_q     <= err_new;
          err_neg_q <= err_neg_new;
          w_q       <= w_new;
        end
        S_ERRW: ew_q <= unit_res[49:0];
        S_NUMX, S_NUMY: num_q <= unit_res[82:0];
        S_DIVX: qx_q <= unit_res[33:0];
        S_DIVY: qy_q <= unit_res[33:0];
        S_ERR2: sq_q <= unit_res[65:0];
        S_COST: cost_q <= cost_new;
        S_NORMX: nx_q <= nsq_new;
        S_NORMY: ny_q <= nsq_new;
        default: begin
          cost_q <= cost_q;
        end
      endcase
    end
  end

  // accumulators, cleared once a result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_acc_q   <= '0;
      gy_acc_q   <= '0;
      cost_acc_q <= '0;
    end else if (state_q == S_ACC) begin
      if (d_q != '0) begin
        gx_acc_q <= gx_next;
        gy_acc_q <= gy_next;
      end
      cost_acc_q <= cost_next;
    end else if (emit) begin
      gx_acc_q   <= '0;
      gy_acc_q   <= '0;
      cost_acc_q <= '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_gx_q   <= gx_acc_q;
      out_gy_q   <= gy_acc_q;
      out_norm_q <= norm_next;
      out_cost_q <= cost_acc_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign grad_x_o       = out_gx_q;
  assign grad_y_o       = out_gy_q;
  assign grad_sq_norm_o = out_norm_q;
  assign cost_sum_o     = out_cost_q;

`include "local_mds_pair_gradient_accumulator_macros.svh"

  `LMGA_ASSERT_SAME(a_unit_busy_not_idle, unit_busy, state_q != S_IDLE)
  `LMGA_ASSERT_NEXT(a_accept_leaves_idle, in_xfer, state_q == S_SQX)
  `LMGA_ASSERT_NEXT(a_emit_clears, emit,
    out_valid_o && gx_acc_q == '0 && gy_acc_q == '0 && cost_acc_q == '0)

endmodule
`default_nettype wire

@@ dv/local_mds_pair_gradient_accumulator_tb.sv @@
`timescale 1ns / 1ps
module local_mds_pair_gradient_accumulator_tb;
  import lmga_pkg::*;

  localparam logic [2:0] AddrLambda = 3'd0;
  localparam logic [2:0] AddrRadius = 3'd4;
  localparam logic [63:0] SatMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint GradHi = 64'sd140737488355327;
  localparam longint GradLo = -64'sd140737488355328;

  typedef struct {
    logic [47:0] gx;
    logic [47:0] gy;
    logic [62:0] norm;
    logic [62:0] cost;
  } grad_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] self_x_i = '0;
  logic signed [31:0] self_y_i = '0;
  logic signed [31:0] other_x_i = '0;
  logic signed [31:0] other_y_i = '0;
  logic [31:0] orig_distance_i = '0;
  logic [31:0] final_threshold_i = '0;
  logic last_pair_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [47:0] grad_x_o;
  logic signed [47:0] grad_y_o;
  logic [62:0] grad_sq_norm_o;
  logic [62:0] cost_sum_o;

  local_mds_pair_gradient_accumulator dut (.*);

  // shadow registers and accumulators of the predictor
  logic [16:0] lambda_shadow = 17'd32768;
  logic [31:0] radius_shadow = '0;
  longint grad_x_sum = 0;
  longint grad_y_sum = 0;
  logic [63:0] cost_total = '0;
  grad_result_t pending_results[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("local_mds_pair_gradient_accumulator_tb: FAIL");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(input logic [127:0] v);
    logic [127:0] rem, trial;
    logic [63:0] root;
    rem = '0;
    root = '0;
    for (int k = 32; k >= 0; k--) begin
      rem = (rem << 2) | ((v >> (2 * k)) & 128'd3);
      trial = ({64'b0, root} << 2) | 128'd1;
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 64'd1;
      end
    end
    return root;
  endfunction

  function automatic longint axis_term(input logic [63:0] err, input bit err_neg,
                                       input logic [63:0] w, input longint delta,
                                       input logic [63:0] d);
    logic [127:0] mag, prod, q;
    mag = (delta < 0) ? 128'(-delta) : 128'(delta);
    prod = {64'b0, err} * {64'b0, w} * mag;
    q = prod / ({64'b0, d} << 16);
    return (err_neg != (delta < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint clamp_grad(input longint acc, input longint term);
    longint s;
    s = acc + term;
    if (s > GradHi) return GradHi;
    if (s < GradLo) return GradLo;
    return s;
  endfunction

  function automatic logic [63:0] sum_clamp(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, SatMax}) ? SatMax : s[63:0];
  endfunction

  function automatic logic [63:0] square_clamp(input longint g);
    logic [127:0] m, p;
    m = (g < 0) ? 128'(-g) : 128'(g);
    p = m * m;
    return (p > {64'b0, SatMax}) ? SatMax : p[63:0];
  endfunction

  // work out one pair and queue the result on the last pair
  function automatic void accumulate_pair(input logic signed [31:0] sx, sy, ox, oy,
                                          input logic [31:0] orig_dist, thr,
                                          input logic last);
    longint dx, dy;
    logic [63:0] ax, ay, d, lam, w, err, cost;
    logic [127:0] sq, prod;
    bit err_neg;
    grad_result_t r;
    dx = longint'(ox) - longint'(sx);
    dy = longint'(oy) - longint'(sy);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sq = {64'b0, ax} * {64'b0, ax} + {64'b0, ay} * {64'b0, ay};
    d = int_sqrt(sq);
    lam = (lambda_shadow > WeightOne) ? 64'd65536 : 64'(lambda_shadow);
    w = 0;
    if (orig_dist < radius_shadow || orig_dist < thr) w = w + lam;
    if (d < radius_shadow || d < thr) w = w + 64'd65536 - lam;
    err_neg = d > orig_dist;
    err = err_neg ? d - orig_dist : 64'(orig_dist) - d;
    // zero output distance leaves the gradient alone
    if (d != 0) begin
      grad_x_sum = clamp_grad(grad_x_sum, axis_term(err, err_neg, w, dx, d));
      grad_y_sum = clamp_grad(grad_y_sum, axis_term(err, err_neg, w, dy, d));
    end
    prod = {64'b0, err} * {64'b0, err} * {64'b0, w};
    cost = ((prod >> 79) != 0) ? SatMax : prod[79:16];
    cost_total = sum_clamp(cost_total, cost);
    if (last) begin
      r.gx = grad_x_sum[47:0];
      r.gy = grad_y_sum[47:0];
      r.norm = sum_clamp(square_clamp(grad_x_sum), square_clamp(grad_y_sum));
      r.cost = cost_total[62:0];
      pending_results.insert(pending_results.size(), r);
      grad_x_sum = 0;
      grad_y_sum = 0;
      cost_total = '0;
    end
  endfunction

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrLambda) lambda_shadow = data[16:0];
    else radius_shadow = data;
  endtask

  task automatic send_pair(input logic signed [31:0] sx, sy, ox, oy,
                           input logic [31:0] orig_dist, thr, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    self_x_i <= sx;
    self_y_i <= sy;
    other_x_i <= ox;
    other_y_i <= oy;
    orig_distance_i <= orig_dist;
    final_threshold_i <= thr;
    last_pair_i <= last;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    accumulate_pair(sx, sy, ox, oy, orig_dist, thr, last);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  // result transfer check and receiver stalls
  always @(posedge clk_i) begin
    grad_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (grad_x_o !== e.gx) begin
          $error("grad_x exp %h got %h", e.gx, grad_x_o);
          fail_count++;
        end
        if (grad_y_o !== e.gy) begin
          $error("grad_y exp %h got %h", e.gy, grad_y_o);
          fail_count++;
        end
        if (grad_sq_norm_o !== e.norm) begin
          $error("grad_sq_norm exp %h got %h", e.norm, grad_sq_norm_o);
          fail_count++;
        end
        if (cost_sum_o !== e.cost) begin
          $error("cost_sum exp %h got %h", e.cost, cost_sum_o);
          fail_count++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
      1: return 32'($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed;
    send_idle_pct = 13;
    recv_idle_pct = 60;
    // coincident points, then extreme spans at reset settings
    send_pair(32'sd5, 32'sd7, 32'sd5, 32'sd7, 32'h0001_0000, 32'h0002_0000, 1'b1);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h0, 32'h0, 1'b1);
    send_pair(32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'hFFFF_FFFF, 1'b0);
    send_pair(32'h0, 32'h0, 32'hFFFD_0000, 32'hFFFC_0000, 32'hFFFF_FFFF, 32'h0, 1'b1);
    drain();
    write_reg(AddrLambda, 32'd0);
    write_reg(AddrRadius, 32'hFFFF_FFFF);
    send_pair(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0, 1'b0);
    send_pair(32'h1234_5678, 32'hEDCB_A987, 32'h1234_5678, 32'hEDCB_A987,
              32'h0005_0000, 32'h0, 1'b0);
    send_pair(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'h0, 1'b1);
    drain();
    // lambda above one is clamped to one
    write_reg(AddrLambda, 32'h0001_FFFF);
    write_reg(AddrRadius, 32'h0001_0000);
    send_pair(32'h0, 32'h0, 32'h0000_8000, 32'h0000_8000, 32'h0000_4000, 32'h0, 1'b0);
    send_pair(32'h0, 32'h0, 32'h4000_0000, 32'hC000_0000, 32'h0, 32'h0, 1'b1);
    drain();
    write_reg(AddrLambda, 32'd65536);
    write_reg(AddrRadius, 32'h0);
    send_pair(32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h0, 32'hFFFF_FFFF, 1'b1);
    drain();
  endtask

  task automatic test_random(input int sidle, input int ridle, input int n_items);
    int sent, pairs, mode;
    logic signed [31:0] sx, sy, ox, oy;
    logic [31:0] orig_dist, thr;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    sent = 0;
    while (sent < n_items) begin
      // one point with a short run of pairs
      mode = $urandom_range(0, 2);
      sx = rand_coord(mode);
      sy = rand_coord(mode);
      thr = (mode == 2) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
      pairs = $urandom_range(1, 5);
      for (int p = 0; p < pairs; p++) begin
        if ($urandom_range(15) == 0) begin
          ox = sx;
          oy = sy;
        end else begin
          ox = rand_coord(mode);
          oy = rand_coord(mode);
        end
        orig_dist = (mode == 2 || $urandom_range(7) == 0) ? $urandom
                                                           : $urandom_range(0, 32'h00FF_FFFF);
        send_pair(sx, sy, ox, oy, orig_dist, thr,
                  (p == pairs - 1) || ($urandom_range(31) == 0));
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_reg(AddrLambda, 32'd32768);
    write_reg(AddrRadius, 32'h0010_0000);
    test_random(13, 60, 150);
    write_reg(AddrLambda, $urandom_range(0, 65536));
    write_reg(AddrRadius, $urandom);
    test_random(60, 13, 150);
    write_reg(AddrLambda, 32'd12000);
    write_reg(AddrRadius, 32'h0000_4000);
    test_random(0, 0, 150);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("local_mds_pair_gradient_accumulator_tb: PASS");
    end else begin
      $display("local_mds_pair_gradient_accumulator_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/lmga_pkg.sv
sv/lmga_iter_unit.sv
sv/local_mds_pair_gradient_accumulator.sv
dv/local_mds_pair_gradient_accumulator_tb.sv
